[hdl/dda_pkg.sv]
// ----------------------------------------------------------------------------
// dda_pkg
// Shared widths, codes and controller/datapath interface types for the
// DDA line rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COORD_BITS    = 13;
    localparam int FRAC_BITS     = 16;
    localparam int COLOR_BITS    = 24;
    // Accumulator: sign, integer part and fraction.
    localparam int ACC_BITS      = COORD_BITS + FRAC_BITS + 1;
    // Slope magnitude is at most 1.0, so it needs one integer bit.
    localparam int DIV_STEPS     = FRAC_BITS + 1;
    localparam int CNT_BITS      = $clog2(DIV_STEPS);

    localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_USED_BITS = 2 * COORD_BITS + COLOR_BITS;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS  = OUT_DATA_BITS - OUT_USED_BITS;

    localparam logic [COLOR_BITS-1:0] COLOR_RESET = {COLOR_BITS{1'b1}};

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef enum logic [1:0] {
        MODE_VERT = 2'd0,
        MODE_HORZ = 2'd1,
        MODE_XMAJ = 2'd2,
        MODE_YMAJ = 2'd3
    } t_mode;

    typedef struct packed {
        logic load_start;   // latch a new line and emit its first pixel
        logic exec_step;    // advance one pixel and emit it
        logic div_step;     // one quotient bit of the slope division
        logic div_last;     // final quotient bit, write the slope
    } t_dp_cmd;

    typedef struct packed {
        logic start_div;    // the incoming start needs a slope division
        logic step_done;    // the next step emits the end pixel
    } t_dp_status;

endpackage

[hdl/dda_line_rasterizer_top.sv]
// ----------------------------------------------------------------------------
// dda_line_rasterizer_top
// DDA line rasterizer: a start beat gives two endpoints and yields the first
// pixel; each step beat of a live line yields the next, tlast on the end one.
//
//  Channel   Dir  Handshake            Payload
//  s_*       in   tvalid / tready      tuser: opcode; tdata: endpoints
//  m_*       out  tvalid / tready      tdata: pixel x, y, color; tlast: end
//  cfg_*     in   write enable only    draw color
//
// Steps are taken back to back while the output register drains. A start
// beat for a sloped line also runs the slope division: the slope is built by
// a restoring divider, one quotient bit per cycle, and s_tready stays low
// meanwhile. Reset is synchronous, active low. The output register holds a
// pixel while m_tready is low; a new beat is taken only when that register
// is empty or is read in the same cycle.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_top import dda_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [COLOR_BITS-1:0]    i_cfg_wr_data,
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    // [12:0] first_x, [25:13] first_y, [38:26] second_x, [51:39] second_y
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,
    // [0] opcode
    input  logic                     i_s_tuser,
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // [12:0] pixel_x, [25:13] pixel_y, [49:26] pixel_color
    output logic [OUT_DATA_BITS-1:0] o_m_tdata,
    output logic                     o_m_tlast
);

    t_dp_cmd                      w_cmd;
    t_dp_status                   w_status;
    logic signed [COORD_BITS-1:0] w_pixel_x, w_pixel_y;
    logic [COLOR_BITS-1:0]        w_pixel_color;

    dda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_opcode   (i_s_tuser),
        .i_m_tready (i_m_tready),
        .i_status   (w_status),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (w_cmd)
    );

    dda_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_first_x     ($signed(i_s_tdata[0*COORD_BITS +: COORD_BITS])),
        .i_first_y     ($signed(i_s_tdata[1*COORD_BITS +: COORD_BITS])),
        .i_second_x    ($signed(i_s_tdata[2*COORD_BITS +: COORD_BITS])),
        .i_second_y    ($signed(i_s_tdata[3*COORD_BITS +: COORD_BITS])),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_pixel_x     (w_pixel_x),
        .o_pixel_y     (w_pixel_y),
        .o_pixel_color (w_pixel_color),
        .o_last_pixel  (o_m_tlast)
    );

    assign o_m_tdata = {{OUT_PAD_BITS{1'b0}}, w_pixel_color, w_pixel_y, w_pixel_x};

    // No input beat is taken while the slope divider runs.
    a_no_accept_in_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_step |-> !o_s_tready)
        else $error("input accepted during slope division");

    // A start beat always yields a first pixel that is not the end pixel.
    a_start_emits_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == OP_START))
        |=> (o_m_tvalid && !o_m_tlast))
        else $error("start beat did not produce a first pixel");

    // A sloped start moves straight into the divider.
    a_start_enters_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_start && w_status.start_div) |=> w_cmd.div_step)
        else $error("slope division did not begin after start");

    // The input side opens only when the output register has room.
    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (!o_m_tvalid || i_m_tready))
        else $error("input ready while output register is full");

endmodule

[hdl/dda_ctrl.sv]
// ----------------------------------------------------------------------------
// dda_ctrl
// Controller: input handshake, output valid, line activity and the
// sequencing of the slope division.
// ----------------------------------------------------------------------------
module dda_ctrl import dda_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_opcode,
    input  logic       i_m_tready,
    input  t_dp_status i_status,
    output logic       o_s_tready,
    output logic       o_m_tvalid,
    output t_dp_cmd    o_cmd
);

    typedef enum logic {
        S_READY  = 1'b0,
        S_DIVIDE = 1'b1
    } t_state;

    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_STEPS - 1);

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic                r_active, n_active;
    logic                r_out_valid, n_out_valid;
    logic                accept;

    always_comb begin
        o_s_tready  = (r_state == S_READY) && (!r_out_valid || i_m_tready);
        accept      = i_s_tvalid && o_s_tready;
        o_cmd       = '0;
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_active    = r_active;
        n_out_valid = r_out_valid && !i_m_tready;

        unique case (r_state)
            S_READY: begin
                if (accept) begin
                    if (i_opcode == OP_START) begin
                        o_cmd.load_start = 1'b1;
                        n_active         = 1'b1;
                        n_out_valid      = 1'b1;
                        if (i_status.start_div) begin
                            n_state = S_DIVIDE;
                            n_cnt   = '0;
                        end
                    end else if (r_active) begin
                        o_cmd.exec_step = 1'b1;
                        n_out_valid     = 1'b1;
                        if (i_status.step_done) begin
                            n_active = 1'b0;
                        end
                    end
                end
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_LAST) begin
                    o_cmd.div_last = 1'b1;
                    n_state        = S_READY;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = S_READY;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_READY;
            r_cnt       <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

[hdl/dda_dp.sv]
// ----------------------------------------------------------------------------
// dda_dp
// Datapath: endpoint ordering and mode decode, a restoring divider for the
// Q.16 slope, the major/minor step registers and the output payload.
// ----------------------------------------------------------------------------
module dda_dp import dda_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [COLOR_BITS-1:0]        i_cfg_wr_data,
    input  logic signed [COORD_BITS-1:0] i_first_x,
    input  logic signed [COORD_BITS-1:0] i_first_y,
    input  logic signed [COORD_BITS-1:0] i_second_x,
    input  logic signed [COORD_BITS-1:0] i_second_y,
    input  t_dp_cmd                      i_cmd,
    output t_dp_status                   o_status,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic [COLOR_BITS-1:0]        o_pixel_color,
    output logic                         o_last_pixel
);

    localparam logic [FRAC_BITS-1:0] FRAC_HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS:0] MAJOR_STEP = 1;

    // Line state.
    logic [COLOR_BITS-1:0]        r_color;
    t_mode                        r_mode;
    logic                         r_step_down;
    logic signed [COORD_BITS-1:0] r_major;
    logic signed [COORD_BITS-1:0] r_stop;
    logic signed [COORD_BITS-1:0] r_end_x;
    logic signed [COORD_BITS-1:0] r_end_y;
    logic signed [ACC_BITS-1:0]   r_acc;
    logic signed [ACC_BITS-1:0]   r_slope;

    // Divider.
    logic [COORD_BITS:0]          r_rem;
    logic [COORD_BITS-1:0]        r_den;
    logic [FRAC_BITS:0]           r_quo;
    logic                         r_neg;

    // Output payload.
    logic signed [COORD_BITS-1:0] r_px;
    logic signed [COORD_BITS-1:0] r_py;
    logic [COLOR_BITS-1:0]        r_pcolor;
    logic                         r_plast;

    // Start decode.
    logic                         swap;
    logic signed [COORD_BITS-1:0] start_x, start_y, end_x, end_y;
    logic signed [COORD_BITS:0]   dx, dy, dy_abs;
    logic [COORD_BITS-1:0]        dx_mag, dy_mag;
    t_mode                        mode;
    logic                         y_rises;
    logic                         sloped;
    logic signed [COORD_BITS-1:0] init_major, init_stop, init_minor;
    logic [COORD_BITS-1:0]        div_num, div_den;

    // Divider and step.
    logic                         ge;
    logic [COORD_BITS:0]          rem_sub;
    logic [FRAC_BITS:0]           quo_next;
    logic [ACC_BITS-1:0]          quo_ext;
    logic signed [COORD_BITS:0]   next_major, stop_ext;
    logic                         done;
    logic signed [ACC_BITS-1:0]   acc_sum;
    logic signed [COORD_BITS-1:0] next_c, rnd;

    always_comb begin
        swap    = i_first_x > i_second_x;
        start_x = swap ? i_second_x : i_first_x;
        start_y = swap ? i_second_y : i_first_y;
        end_x   = swap ? i_first_x  : i_second_x;
        end_y   = swap ? i_first_y  : i_second_y;
        dx      = $signed({end_x[COORD_BITS-1], end_x})
                - $signed({start_x[COORD_BITS-1], start_x});
        dy      = $signed({end_y[COORD_BITS-1], end_y})
                - $signed({start_y[COORD_BITS-1], start_y});
        dy_abs  = dy[COORD_BITS] ? -dy : dy;
        dx_mag  = dx[COORD_BITS-1:0];
        dy_mag  = dy_abs[COORD_BITS-1:0];
        y_rises = start_y < end_y;

        if (dx_mag == '0) begin
            mode = MODE_VERT;
        end else if (dy_mag == '0) begin
            mode = MODE_HORZ;
        end else if (dy_mag < dx_mag) begin
            mode = MODE_XMAJ;
        end else begin
            mode = MODE_YMAJ;
        end

        unique case (mode)
            MODE_VERT: begin
                // The interior always runs upward between the two y values.
                init_major = y_rises ? start_y : end_y;
                init_stop  = y_rises ? end_y : start_y;
                init_minor = start_x;
            end
            MODE_HORZ: begin
                init_major = start_x;
                init_stop  = end_x;
                init_minor = start_y;
            end
            MODE_XMAJ: begin
                init_major = start_x;
                init_stop  = end_x;
                init_minor = start_y;
            end
            MODE_YMAJ: begin
                init_major = start_y;
                init_stop  = end_y;
                init_minor = start_x;
            end
        endcase

        div_num = (mode == MODE_YMAJ) ? dx_mag : dy_mag;
        div_den = (mode == MODE_YMAJ) ? dy_mag : dx_mag;

        sloped = (mode == MODE_XMAJ) || (mode == MODE_YMAJ);
    end

    // One quotient bit per cycle; the remainder stays below twice the divisor.
    always_comb begin
        ge       = r_rem >= {1'b0, r_den};
        rem_sub  = ge ? (r_rem - {1'b0, r_den}) : r_rem;
        quo_next = {r_quo[FRAC_BITS-1:0], ge};
        quo_ext  = {{(ACC_BITS-FRAC_BITS-1){1'b0}}, quo_next};
    end

    always_comb begin
        stop_ext   = $signed({r_stop[COORD_BITS-1], r_stop});
        next_major = r_step_down ? ($signed({r_major[COORD_BITS-1], r_major}) - MAJOR_STEP)
                                 : ($signed({r_major[COORD_BITS-1], r_major}) + MAJOR_STEP);
        done       = r_step_down ? (next_major <= stop_ext) : (next_major >= stop_ext);
        next_c     = next_major[COORD_BITS-1:0];
        // The accumulator carries a built-in half, so this is round half up.
        acc_sum    = r_acc + r_slope;
        rnd        = acc_sum[FRAC_BITS +: COORD_BITS];
    end

    assign o_status = '{start_div: sloped, step_done: done};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= COLOR_RESET;
        end else if (i_cfg_wr_en) begin
            r_color <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_start) begin
            r_mode      <= mode;
            r_step_down <= (mode == MODE_YMAJ) && dy[COORD_BITS];
            r_major     <= init_major;
            r_stop      <= init_stop;
            r_end_x     <= end_x;
            r_end_y     <= end_y;
            r_acc       <= $signed({init_minor[COORD_BITS-1], init_minor, FRAC_HALF});
            r_slope     <= '0;
            r_rem       <= {1'b0, div_num};
            r_den       <= div_den;
            r_quo       <= '0;
            r_neg       <= (mode == MODE_XMAJ) && dy[COORD_BITS];
            r_px        <= start_x;
            r_py        <= start_y;
            r_pcolor    <= r_color;
            r_plast     <= 1'b0;
        end

        if (i_cmd.div_step) begin
            r_rem <= {rem_sub[COORD_BITS-1:0], 1'b0};
            r_quo <= quo_next;
        end

        if (i_cmd.div_last) begin
            r_slope <= r_neg ? $signed(-quo_ext) : $signed(quo_ext);
        end

        if (i_cmd.exec_step) begin
            r_pcolor <= r_color;
            if (done) begin
                r_px    <= r_end_x;
                r_py    <= r_end_y;
                r_plast <= 1'b1;
            end else begin
                r_major <= next_c;
                r_acc   <= acc_sum;
                r_plast <= 1'b0;
                unique case (r_mode)
                    MODE_VERT: begin
                        r_px <= r_end_x;
                        r_py <= next_c;
                    end
                    MODE_HORZ: begin
                        r_px <= next_c;
                        r_py <= r_end_y;
                    end
                    MODE_XMAJ: begin
                        r_px <= next_c;
                        r_py <= rnd;
                    end
                    MODE_YMAJ: begin
                        r_px <= rnd;
                        r_py <= next_c;
                    end
                endcase
            end
        end
    end

    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_pixel_color = r_pcolor;
    assign o_last_pixel  = r_plast;

endmodule

[tb/tb_dda_line_rasterizer_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dda_line_rasterizer_top
// Self-checking bench for the DDA line rasterizer. It runs a short table of
// hand-picked lines first, then random lines across several draw colors.
// Each accepted beat goes through a local line-walk predictor, and every
// output pixel is compared with the oldest predicted pixel.
// ----------------------------------------------------------------------------
module tb_dda_line_rasterizer_top;
    import dda_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASE_BEATS  = 290;
    localparam int SETTLE_TICKS = 25;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct {
        coord_t                x;
        coord_t                y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
    } pixel_t;

    typedef struct {
        logic   op;
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        bit     typed;
        coord_t ex;
        coord_t ey;
        logic   el;
    } line_row_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic [COLOR_BITS-1:0]    i_cfg_wr_data;
    logic                     i_s_tvalid;
    logic                     o_s_tready;
    logic [IN_DATA_BITS-1:0]  i_s_tdata;
    logic                     i_s_tuser;
    logic                     o_m_tvalid;
    logic                     i_m_tready;
    logic [OUT_DATA_BITS-1:0] o_m_tdata;
    logic                     o_m_tlast;

    dda_line_rasterizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast)
    );

    // Predictor state of the line walk.
    logic [COLOR_BITS-1:0] pen_color;
    bit                    line_on;
    t_mode                 walk_mode;
    bit                    going_down;
    longint                major_pos;
    longint                minor_acc;
    longint                slope_step;
    longint                end_x;
    longint                end_y;

    pixel_t pending_pixels[$];
    int     error_count;
    int     idle_cycles;
    int     beats_sent;
    int     burst_left;

    line_row_t line_plan[26] = '{
        '{OP_STEP,     0,     0,     0,     0, 0,     0,     0, 0},
        '{OP_START,    0,     0,     0,     0, 1,     0,     0, 0},
        '{OP_STEP,     0,     0,     0,     0, 1,     0,     0, 1},
        '{OP_START,    5,     7,     5,     3, 1,     5,     7, 0},
        '{OP_STEP,     0,     0,     0,     0, 0,     0,     0, 0},
        '{OP_STEP,     0,     0,     0,     0, 0,     0,     0, 0},
        '{OP_STEP,     0,     0,     0,     0, 0,     0,     0, 0},
        '{OP_STEP,     0,     0,     0,     0, 1,     5,     3, 1},
        '{OP_START,    9,     2,     6,     2, 1,     6,     2, 0},
        '{OP_STEP,     0,     0,     0,     0, 0,     0,     0, 0},
        '{OP_STEP,     0,     0,     0,     0, 0,     0,     0, 0},
        '{OP_STEP,     0,     0,     0,     0, 1,     9,     2, 1},
        '{OP_START,    0,     0,     3,    -3, 1,     0,     0, 0},
        '{OP_STEP,     0,     0,     0,     0, 0,     0,     0, 0},
        '{OP_STEP,     0,     0,     0,     0, 0,     0,     0, 0},
        '{OP_STEP,     0,     0,     0,     0, 1,     3,    -3, 1},
        '{OP_START,    0,     0,     4,    -1, 1,     0,     0, 0},
        '{OP_STEP,     0,     0,     0,     0, 0,     0,     0, 0},
        '{OP_STEP,     0,     0,     0,     0, 0,     0,     0, 0},
        '{OP_STEP,     0,     0,     0,     0, 0,     0,     0, 0},
        '{OP_START, -4096, -4096,  4095,  4095, 1, -4096, -4096, 0},
        '{OP_START,  4095,  4095, -4096, -4096, 1, -4096, -4096, 0},
        '{OP_START, -4096,  4095,  4095, -4096, 1, -4096,  4095, 0},
        '{OP_STEP,     0,     0,     0,     0, 0,     0,     0, 0},
        '{OP_START,  4095,     0,  4095, -4096, 1,  4095,     0, 0},
        '{OP_STEP,     0,     0,     0,     0, 0,     0,     0, 0}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Walks the line one beat further and returns the pixel it yields, if any.
    task automatic walk_line(input logic op, input coord_t ax, input coord_t ay,
                             input coord_t bx, input coord_t by,
                             output bit emits, output pixel_t px);
        longint sx, sy, dx, dy, ady, nxt, stop, px_x, px_y;
        bit     done;
        emits = 1'b0;
        px_x  = 0;
        px_y  = 0;
        done  = 1'b0;
        if (op == OP_START) begin
            if (ax <= bx) begin
                sx = ax; sy = ay; end_x = bx; end_y = by;
            end else begin
                sx = bx; sy = by; end_x = ax; end_y = ay;
            end
            dx = end_x - sx;
            dy = end_y - sy;
            ady = (dy < 0) ? -dy : dy;
            going_down = 1'b0;
            slope_step = 0;
            if (dx == 0) begin
                // Vertical lines always walk upward; the accumulator holds the top.
                walk_mode = MODE_VERT;
                major_pos = (sy < end_y) ? sy : end_y;
                minor_acc = (sy < end_y) ? end_y : sy;
            end else if (dy == 0) begin
                walk_mode = MODE_HORZ;
                major_pos = sx;
                minor_acc = 0;
            end else if (ady < dx) begin
                walk_mode  = MODE_XMAJ;
                major_pos  = sx;
                slope_step = (ady <<< FRAC_BITS) / dx;
                if (dy < 0) slope_step = -slope_step;
                minor_acc  = sx * 0 + (sy <<< FRAC_BITS);
            end else begin
                walk_mode  = MODE_YMAJ;
                going_down = (dy < 0);
                major_pos  = sy;
                slope_step = (dx <<< FRAC_BITS) / ady;
                minor_acc  = sx <<< FRAC_BITS;
            end
            line_on = 1'b1;
            emits   = 1'b1;
            px_x    = sx;
            px_y    = sy;
        end else if (line_on) begin
            emits = 1'b1;
            nxt = going_down ? major_pos - 1 : major_pos + 1;
            case (walk_mode)
                MODE_VERT: stop = minor_acc;
                MODE_YMAJ: stop = end_y;
                default:   stop = end_x;
            endcase
            done = going_down ? (nxt <= stop) : (nxt >= stop);
            if (done) begin
                line_on = 1'b0;
                px_x    = end_x;
                px_y    = end_y;
            end else begin
                major_pos = nxt;
                case (walk_mode)
                    MODE_VERT: begin
                        px_x = end_x;
                        px_y = nxt;
                    end
                    MODE_HORZ: begin
                        px_x = nxt;
                        px_y = end_y;
                    end
                    MODE_XMAJ: begin
                        minor_acc = minor_acc + slope_step;
                        px_x = nxt;
                        // Round half up: floor(acc + 0.5).
                        px_y = (minor_acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                    end
                    default: begin
                        minor_acc = minor_acc + slope_step;
                        px_x = (minor_acc + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
                        px_y = nxt;
                    end
                endcase
            end
        end
        px.x     = coord_t'(px_x);
        px.y     = coord_t'(px_y);
        px.color = pen_color;
        px.last  = done;
    endtask

    // Offers one beat in bursts with random gaps and predicts it on acceptance.
    task automatic send_beat(input logic op, input coord_t ax, input coord_t ay,
                             input coord_t bx, input coord_t by, input bit typed,
                             input coord_t ex, input coord_t ey, input logic el);
        bit     emits;
        pixel_t px;
        int     gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
            gap = $urandom_range(1, 15);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {{(IN_DATA_BITS - 4 * COORD_BITS){1'b0}}, by, bx, ay, ax};
        do @(posedge i_clk); while (!o_s_tready);
        burst_left = burst_left - 1;
        if (op == OP_START || line_on) beats_sent = beats_sent + 1;
        walk_line(op, ax, ay, bx, by, emits, px);
        if (emits) begin
            if (typed) begin
                px.x    = ex;
                px.y    = ey;
                px.last = el;
            end
            pending_pixels.push_back(px);
        end
    endtask

    // Drains the block and writes a new draw color.
    task automatic load_color(input logic [COLOR_BITS-1:0] color);
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= color;
        @(posedge i_clk);
        pen_color = color;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic coord_t clamp_coord(input longint v);
        if (v > 4095) return coord_t'(4095);
        if (v < -4096) return coord_t'(-4096);
        return coord_t'(v);
    endfunction

    function automatic coord_t any_coord();
        return coord_t'(int'($urandom_range(0, 8191)) - 4096);
    endfunction

    // A well-formed line with random content, sometimes cut short by a new start.
    task automatic draw_random_line();
        coord_t ax, ay, bx, by, tmp;
        int     reach, dx, dy, kind;
        bit     cut;
        ax    = any_coord();
        ay    = any_coord();
        reach = ($urandom_range(0, 19) == 0) ? 200 : 12;
        kind  = $urandom_range(0, 9);
        dx    = int'($urandom_range(0, 2 * reach)) - reach;
        dy    = int'($urandom_range(0, 2 * reach)) - reach;
        case (kind)
            0: dx = 0;
            1: dy = 0;
            2: dy = ($urandom_range(0, 1) != 0) ? dx : -dx;
            3: begin
                dx = 0;
                dy = 0;
            end
            default: ;
        endcase
        bx = clamp_coord(longint'(ax) + dx);
        by = clamp_coord(longint'(ay) + dy);
        if ($urandom_range(0, 1) != 0) begin
            tmp = ax; ax = bx; bx = tmp;
            tmp = ay; ay = by; by = tmp;
        end
        cut = ($urandom_range(0, 9) == 0);
        send_beat(OP_START, ax, ay, bx, by, 0, 0, 0, 0);
        while (line_on && !(cut && $urandom_range(0, 3) == 0))
            send_beat(OP_STEP, any_coord(), any_coord(), any_coord(), any_coord(),
                      0, 0, 0, 0);
    endtask

    // Output side: changes its stall style every so often.
    initial begin
        int style;
        int style_left;
        int run_left;
        i_m_tready = 1'b0;
        style_left = 0;
        run_left   = 0;
        style      = 0;
        forever begin
            @(negedge i_clk);
            if (style_left == 0) begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(64, 256);
            end
            style_left = style_left - 1;
            case (style)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= $urandom_range(0, 1);
                2: i_m_tready <= ($urandom_range(0, 3) == 0);
                default: begin
                    if (run_left == 0) begin
                        run_left   = $urandom_range(1, 12);
                        i_m_tready <= ~i_m_tready;
                    end
                    run_left = run_left - 1;
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        pixel_t want;
        pixel_t got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.x     = o_m_tdata[COORD_BITS-1:0];
            got.y     = o_m_tdata[2*COORD_BITS-1:COORD_BITS];
            got.color = o_m_tdata[OUT_USED_BITS-1:2*COORD_BITS];
            got.last  = o_m_tlast;
            if (pending_pixels.size() == 0) begin
                error_count = error_count + 1;
                $display("%0t: unexpected pixel x=%0d y=%0d color=%06h last=%0b",
                         $time, got.x, got.y, got.color, got.last);
            end else begin
                want = pending_pixels.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
                    got.last !== want.last) begin
                    error_count = error_count + 1;
                    $display("%0t: expected x=%0d y=%0d color=%06h last=%0b, got x=%0d y=%0d color=%06h last=%0b",
                             $time, want.x, want.y, want.color, want.last,
                             got.x, got.y, got.color, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
        $display("dda_line_rasterizer_top: mismatch");
        $finish;
    end

    initial begin
        logic [COLOR_BITS-1:0] palette[5];
        int r;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tuser     = OP_START;
        idle_cycles   = 0;
        error_count   = 0;
        beats_sent    = 0;
        burst_left    = 0;
        pen_color     = COLOR_RESET;
        line_on       = 1'b0;
        walk_mode     = MODE_VERT;
        going_down    = 1'b0;
        major_pos     = 0;
        minor_acc     = 0;
        slope_step    = 0;
        end_x         = 0;
        end_y         = 0;
        palette[0]    = 24'h000000;
        palette[1]    = 24'h555555;
        palette[2]    = 24'hAAAAAA;
        palette[3]    = COLOR_BITS'($urandom);
        palette[4]    = 24'hFFFFFF;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (line_plan[i])
            send_beat(line_plan[i].op, line_plan[i].ax, line_plan[i].ay,
                      line_plan[i].bx, line_plan[i].by, line_plan[i].typed,
                      line_plan[i].ex, line_plan[i].ey, line_plan[i].el);

        for (int ph = 0; ph < 5; ph++) begin
            load_color(palette[ph]);
            beats_sent = 0;
            while (beats_sent < PHASE_BEATS) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    draw_random_line();
                end else if (r < 92) begin
                    // Fully random endpoints, usually dropped after a few steps.
                    send_beat(OP_START, any_coord(), any_coord(), any_coord(),
                              any_coord(), 0, 0, 0, 0);
                    repeat ($urandom_range(0, 3))
                        send_beat(OP_STEP, any_coord(), any_coord(), any_coord(),
                                  any_coord(), 0, 0, 0, 0);
                end else begin
                    send_beat(OP_STEP, any_coord(), any_coord(), any_coord(),
                              any_coord(), 0, 0, 0, 0);
                end
            end
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (error_count == 0)
            $display("dda_line_rasterizer_top: match");
        else
            $display("dda_line_rasterizer_top: mismatch");
        $finish;
    end

endmodule

[dda_line_rasterizer_top.f]
hdl/dda_pkg.sv
hdl/dda_ctrl.sv
hdl/dda_dp.sv
hdl/dda_line_rasterizer_top.sv
tb/tb_dda_line_rasterizer_top.sv
